/* hdl/dnts_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal number token scanner package
// Shared types, character codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dnts_pkg;

  // Character codes.
  localparam logic [7:0] CODE_DOT   = 8'd51;
  localparam logic [7:0] CODE_PLUS  = 8'd45;
  localparam logic [7:0] CODE_MINUS = 8'd46;
  localparam logic [7:0] CODE_D     = 8'd13;
  localparam logic [7:0] CODE_E     = 8'd14;
  localparam logic [8:0] DIGIT_MAX  = 9'd9;

  // Configuration register indexes.
  localparam logic [2:0] REG_OVF_EXP  = 3'd0;
  localparam logic [2:0] REG_UNF_EXP  = 3'd1;
  localparam logic [2:0] REG_EXACT_DIG = 3'd2;
  localparam logic [2:0] REG_EXACT_POW = 3'd3;
  localparam logic [2:0] REG_EXP_DIG  = 3'd4;

  // Register reset values.
  localparam logic [11:0] OVF_EXP_RST   = 12'd309;
  localparam logic [12:0] UNF_EXP_RST   = 13'h1EBC;  // -324
  localparam logic [4:0]  EXACT_DIG_RST = 5'd15;
  localparam logic [5:0]  EXACT_POW_RST = 6'd22;
  localparam logic [2:0]  EXP_DIG_RST   = 3'd7;

  // Exponent bookkeeping.
  localparam logic [21:0] CORR_MAX = 22'h1FFFFF;
  localparam logic [21:0] CORR_MIN = 22'h200000;
  localparam logic [2:0]  EXP_ACC_DIGITS = 3'd6;
  localparam logic [2:0]  EXP_SAT_DIGITS = 3'd7;
  localparam int          CMP_W = 27;

  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_INT_LEAD   = 9'b000000010,
    PH_INT_DIG    = 9'b000000100,
    PH_FRAC_LEAD  = 9'b000001000,
    PH_FRAC_DIG   = 9'b000010000,
    PH_AFTER_MANT = 9'b000100000,
    PH_EXP_SIGN   = 9'b001000000,
    PH_EXP_LEAD   = 9'b010000000,
    PH_EXP_DIG    = 9'b100000000
  } phase_e;

  typedef enum logic [3:0] {
    CT_SCAN  = 4'b0001,
    CT_EXPO  = 4'b0010,
    CT_CLASS = 4'b0100,
    CT_EMIT  = 4'b1000
  } ctrl_e;

  typedef enum logic [2:0] {
    CLS_ZERO      = 3'd0,
    CLS_OVERFLOW  = 3'd1,
    CLS_UNDERFLOW = 3'd2,
    CLS_EXACT     = 3'd3,
    CLS_SCALED    = 3'd4,
    CLS_GENERAL   = 3'd5
  } class_e;

  // Exponent state of the token being scanned.
  typedef struct packed {
    logic signed [23:0] acc;
    logic signed [21:0] corr;
    logic [2:0]         digits;
    logic               neg;
  } exp_info_t;

endpackage

/* hdl/dnts_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dnts_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hdl/dnts_scan.sv */
// ----------------------------------------------------------------------------
// Token scanner
// Walks the number syntax one character a cycle while input is accepted,
// records significand digits in digit memory; keeps exponent and its correction.
// ----------------------------------------------------------------------------
module dnts_scan #(
  parameter int MAX_DIGITS = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_acc_i,
  input  logic [7:0]                    char_code_i,
  input  logic                          token_start_i,
  input  logic                          began_with_dot_i,
  output logic                          done_o,
  output logic                          wr_en_o,
  output logic [$clog2(MAX_DIGITS)-1:0] wr_addr_o,
  output logic [4:0]                    wr_data_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0] count_o,
  output dnts_pkg::exp_info_t           exp_o
);
  import dnts_pkg::*;

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  phase_e    phase_q, phase_d, ph;
  logic [CW-1:0] cnt_q, cnt_d, cnt;
  exp_info_t exp_q, exp_d, ex;
  logic [8:0] mag;
  logic is_zero, is_dig, is_dot, is_exp, is_sign, room, done, wr;

  always_comb begin
    mag     = char_code_i[7] ? (9'd0 - {1'b1, char_code_i}) : {1'b0, char_code_i};
    is_zero = (char_code_i == 8'd0);
    is_dig  = (mag <= DIGIT_MAX);
    is_dot  = (mag == {1'b0, CODE_DOT});
    is_exp  = (mag == {1'b0, CODE_D}) || (mag == {1'b0, CODE_E});
    is_sign = (char_code_i == CODE_PLUS) || (char_code_i == CODE_MINUS);

    // A new token clears the bookkeeping before its first character is seen.
    if (token_start_i) begin
      ph  = began_with_dot_i ? PH_FRAC_LEAD : PH_INT_LEAD;
      cnt = '0;
      ex  = '0;
    end else begin
      ph  = phase_q;
      cnt = cnt_q;
      ex  = exp_q;
    end
    room = (cnt < CW'(MAX_DIGITS));

    // Phases that hand the character on to the next phase without consuming it.
    if (ph == PH_INT_LEAD && !is_zero) ph = PH_INT_DIG;
    if (ph == PH_FRAC_LEAD && !is_zero) ph = PH_FRAC_DIG;
    if (ph == PH_INT_DIG && !is_dig && !is_dot) ph = PH_AFTER_MANT;
    if (ph == PH_FRAC_DIG && !is_dig) ph = PH_AFTER_MANT;
    if (ph == PH_EXP_SIGN && !is_sign) ph = PH_EXP_LEAD;
    if (ph == PH_EXP_LEAD && !is_zero) ph = PH_EXP_DIG;

    phase_d = ph;
    cnt_d   = cnt;
    exp_d   = ex;
    done    = 1'b0;
    wr      = 1'b0;
    case (ph)
      PH_INT_DIG: begin
        if (is_dig) begin
          if (room) begin
            wr    = 1'b1;
            cnt_d = cnt + CW'(1);
          end else if (ex.corr != CORR_MAX) begin
            exp_d.corr = ex.corr + 22'sd1;
          end
        end else begin
          phase_d = (cnt == '0) ? PH_FRAC_LEAD : PH_FRAC_DIG;
        end
      end
      PH_FRAC_LEAD: begin
        if (ex.corr != CORR_MIN) exp_d.corr = ex.corr - 22'sd1;
      end
      PH_FRAC_DIG: begin
        if (room) begin
          wr    = 1'b1;
          cnt_d = cnt + CW'(1);
          if (ex.corr != CORR_MIN) exp_d.corr = ex.corr - 22'sd1;
        end
      end
      PH_AFTER_MANT: begin
        if (is_exp) begin
          phase_d = PH_EXP_SIGN;
        end else begin
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      PH_EXP_SIGN: begin
        exp_d.neg = (char_code_i == CODE_MINUS);
        phase_d   = PH_EXP_LEAD;
      end
      PH_EXP_DIG: begin
        if (is_dig) begin
          if (ex.digits < EXP_ACC_DIGITS) begin
            exp_d.acc = (ex.acc <<< 3) + (ex.acc <<< 1)
                      + {{16{char_code_i[7]}}, char_code_i};
          end
          if (ex.digits < EXP_SAT_DIGITS) exp_d.digits = ex.digits + 3'd1;
        end else begin
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      exp_q   <= '0;
    end else if (in_acc_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      exp_q   <= exp_d;
    end
  end

  assign done_o    = in_acc_i & done;
  assign wr_en_o   = in_acc_i & wr;
  assign wr_addr_o = cnt[AW-1:0];
  assign wr_data_o = char_code_i[4:0];
  assign count_o   = cnt_q;
  assign exp_o     = exp_q;

endmodule

/* hdl/decimal_number_token_scanner_top.sv */
// ----------------------------------------------------------------------------
// Decimal number token scanner, top level
// Scans number tokens one character a cycle and emits the recorded digits
// with the token class and the final decimal exponent.
// ----------------------------------------------------------------------------
// Throughput: one character a cycle while a token is scanned.
// The terminating character stalls input through the exponent and class
// evaluation states, then the run leaves at one item a cycle unless the output
// stalls (one digit memory read per item); input resumes after the last item.
// Reset clears control state and loads the register defaults; the digit
// memory is not cleared.
module decimal_number_token_scanner_top #(
  parameter int MAX_DIGITS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic [1:0]  s_axis_tuser,   // token_start, began_with_dot
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // digit_value, digit_count, final_exponent
  output logic [2:0]  m_axis_tuser,   // number_class
  output logic        m_axis_tlast
);
  import dnts_pkg::*;

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  // Configuration registers.
  logic [11:0] ovf_q;
  logic [12:0] unf_q;
  logic [4:0]  xdig_q;
  logic [5:0]  xpow_q;
  logic [2:0]  edig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q  <= OVF_EXP_RST;
      unf_q  <= UNF_EXP_RST;
      xdig_q <= EXACT_DIG_RST;
      xpow_q <= EXACT_POW_RST;
      edig_q <= EXP_DIG_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_OVF_EXP:   ovf_q  <= cfg_wdata_i[11:0];
        REG_UNF_EXP:   unf_q  <= cfg_wdata_i;
        REG_EXACT_DIG: xdig_q <= cfg_wdata_i[4:0];
        REG_EXACT_POW: xpow_q <= cfg_wdata_i[5:0];
        REG_EXP_DIG:   edig_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  ctrl_e ctrl_q, ctrl_d;
  logic in_acc, done, wr_en, re;
  logic [AW-1:0] wr_addr, raddr;
  logic [4:0] wr_data, rdata;
  logic [CW-1:0] count;
  exp_info_t exp_info;

  assign s_axis_tready = (ctrl_q == CT_SCAN);
  assign in_acc = s_axis_tvalid & s_axis_tready;

  dnts_scan #(.MAX_DIGITS(MAX_DIGITS)) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_acc_i        (in_acc),
    .char_code_i     (s_axis_tdata),
    .token_start_i   (s_axis_tuser[0]),
    .began_with_dot_i(s_axis_tuser[1]),
    .done_o          (done),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .count_o         (count),
    .exp_o           (exp_info)
  );

  dnts_ram #(.WIDTH(5), .DEPTH(MAX_DIGITS)) u_digits (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Exponent and classification.
  logic signed [23:0] expo_q, expo_d;
  logic [9:0] fexp_q, fexp_d;
  class_e cls_q, cls_d;
  logic signed [CMP_W-1:0] e, nn, xdig, xpow, abs_e;
  logic ovf, unf, ex3, ex4;

  always_comb begin
    expo_d = (exp_info.neg ? (24'sd0 - exp_info.acc) : exp_info.acc)
           + {{2{exp_info.corr[21]}}, exp_info.corr};
    e      = {{(CMP_W-24){expo_q[23]}}, expo_q};
    nn     = {{(CMP_W-CW){1'b0}}, count};
    xdig   = {{(CMP_W-5){1'b0}}, xdig_q};
    xpow   = {{(CMP_W-6){1'b0}}, xpow_q};
    abs_e  = e[CMP_W-1] ? -e : e;
    ovf    = (e + nn - CMP_W'(1)) >= $signed({{(CMP_W-12){1'b0}}, ovf_q});
    unf    = (e + nn) <= $signed({{(CMP_W-13){unf_q[12]}}, unf_q});
    ex3    = (nn <= xdig) && (abs_e <= xpow);
    ex4    = (e > xpow) && ((e - xpow + nn) <= xdig);
    if (count == '0) begin
      cls_d = CLS_ZERO;
    end else if (exp_info.digits >= edig_q) begin
      cls_d = exp_info.neg ? CLS_UNDERFLOW : CLS_OVERFLOW;
    end else if (ovf) begin
      cls_d = CLS_OVERFLOW;
    end else if (unf) begin
      cls_d = CLS_UNDERFLOW;
    end else if (ex3) begin
      cls_d = CLS_EXACT;
    end else if (ex4) begin
      cls_d = CLS_SCALED;
    end else begin
      cls_d = CLS_GENERAL;
    end
    // The exponent is only reported for the three finite nonzero classes.
    if (cls_d == CLS_ZERO || cls_d == CLS_OVERFLOW || cls_d == CLS_UNDERFLOW) begin
      fexp_d = '0;
    end else if (e > CMP_W'(511)) begin
      fexp_d = 10'h1FF;
    end else if (e < -CMP_W'(512)) begin
      fexp_d = 10'h200;
    end else begin
      fexp_d = e[9:0];
    end
  end

  // Emission and output register.
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] last_idx;
  logic slot_free, is_last;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [4:0] out_digit_q, out_digit_d, out_count_q, out_count_d;
  logic [9:0] out_exp_q, out_exp_d;
  logic [2:0] out_cls_q, out_cls_d;

  always_comb begin
    last_idx  = (count == '0) ? '0 : count - CW'(1);
    is_last   = (CW'(idx_q) == last_idx);
    slot_free = !out_valid_q || m_axis_tready;

    ctrl_d      = ctrl_q;
    idx_d       = idx_q;
    re          = 1'b0;
    raddr       = idx_q + AW'(1);
    out_valid_d = out_valid_q && !m_axis_tready;
    out_digit_d = out_digit_q;
    out_count_d = out_count_q;
    out_exp_d   = out_exp_q;
    out_cls_d   = out_cls_q;
    out_last_d  = out_last_q;

    case (ctrl_q)
      CT_SCAN: begin
        if (done) ctrl_d = CT_EXPO;
      end
      CT_EXPO: begin
        ctrl_d = CT_CLASS;
      end
      CT_CLASS: begin
        re     = 1'b1;
        raddr  = '0;
        idx_d  = '0;
        ctrl_d = CT_EMIT;
      end
      CT_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_digit_d = (count == '0) ? 5'd0 : rdata;
          out_count_d = count[4:0];
          out_exp_d   = is_last ? fexp_q : 10'd0;
          out_cls_d   = cls_q;
          out_last_d  = is_last;
          if (is_last) begin
            ctrl_d = CT_SCAN;
          end else begin
            re    = 1'b1;
            idx_d = idx_q + AW'(1);
          end
        end
      end
      default: ctrl_d = CT_SCAN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= CT_SCAN;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      ctrl_q      <= ctrl_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_q == CT_EXPO) expo_q <= expo_d;
    if (ctrl_q == CT_CLASS) begin
      cls_q  <= cls_d;
      fexp_q <= fexp_d;
    end
    out_digit_q <= out_digit_d;
    out_count_q <= out_count_d;
    out_exp_q   <= out_exp_d;
    out_cls_q   <= out_cls_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_exp_q, out_count_q, out_digit_q};
  assign m_axis_tuser  = out_cls_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* sim/tb_decimal_number_token_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal number token scanner testbench
// Streams number tokens into the scanner under several register settings and
// handshake pressures, and checks every digit run against a cycle-free model
// of the scanner that is kept alongside the stream.
// ----------------------------------------------------------------------------
module tb_decimal_number_token_scanner_top;
  import dnts_pkg::*;

  localparam int         MAX_DIG     = 25;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASE_CHARS = 55;
  localparam logic [7:0] CODE_SPACE  = 8'd20;

  typedef struct packed {
    logic signed [4:0] digit;
    logic [4:0]        count;
    logic signed [9:0] expo;
    class_e            cls;
    logic              last;
  } digit_out_t;

  typedef struct packed {
    logic [7:0] code;
    logic       start;
    logic       dot;
    logic       known;
    digit_out_t want;
  } char_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [12:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // char_code
  logic [1:0]  s_axis_tuser = '0;   // token_start, began_with_dot
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // digit_value, digit_count, final_exponent
  logic [2:0]  m_axis_tuser;        // number_class
  logic        m_axis_tlast;

  decimal_number_token_scanner_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scanner model state and register copies.
  phase_e scan_ph;
  int     dig_mem [MAX_DIG];
  int     dig_cnt;
  int     exp_corr;
  int     exp_acc;
  int     exp_ndig;
  bit     exp_neg;
  int     ovf_exp;
  int     unf_exp;
  int     exact_dig;
  int     exact_pow;
  int     exp_dig_lim;

  digit_out_t pending_digits[$];
  digit_out_t fresh_run[$];

  int  send_gap_pct = 0;
  int  stall_pct = 0;
  int  errors = 0;
  int  checked = 0;
  int  total_chars = 0;
  int  live_chars = 0;
  int  settings = 1;
  int  quiet_cycles = 0;
  int  class_seen [6];
  bit  tok_first;
  bit  tok_dot;

  char_row_t dir_rows [26];

  function automatic void bump_corr(int d);
    exp_corr = exp_corr + d;
    if (exp_corr > int'($signed(CORR_MAX))) exp_corr = int'($signed(CORR_MAX));
    if (exp_corr < int'($signed(CORR_MIN))) exp_corr = int'($signed(CORR_MIN));
  endfunction

  // Advances the scan by one character; returns 1 when the character ends the
  // token. A phase may hand the same character on to the next phase.
  function automatic bit scan_ends_token(int c);
    int a;
    bit done;
    bit ends;
    a = (c < 0) ? -c : c;
    done = 1'b0;
    ends = 1'b0;
    while (!done) begin
      case (scan_ph)
        PH_INT_LEAD: begin
          if (c == 0) done = 1'b1;
          else scan_ph = PH_INT_DIG;
        end
        PH_INT_DIG: begin
          if (a <= int'(DIGIT_MAX)) begin
            if (dig_cnt < MAX_DIG) begin
              dig_mem[dig_cnt] = c;
              dig_cnt++;
            end else begin
              bump_corr(1);
            end
            done = 1'b1;
          end else if (a == int'(CODE_DOT)) begin
            scan_ph = (dig_cnt == 0) ? PH_FRAC_LEAD : PH_FRAC_DIG;
            done = 1'b1;
          end else begin
            scan_ph = PH_AFTER_MANT;
          end
        end
        PH_FRAC_LEAD: begin
          if (c == 0) begin
            bump_corr(-1);
            done = 1'b1;
          end else begin
            scan_ph = PH_FRAC_DIG;
          end
        end
        PH_FRAC_DIG: begin
          if (a <= int'(DIGIT_MAX)) begin
            if (dig_cnt < MAX_DIG) begin
              dig_mem[dig_cnt] = c;
              dig_cnt++;
              bump_corr(-1);
            end
            done = 1'b1;
          end else begin
            scan_ph = PH_AFTER_MANT;
          end
        end
        PH_AFTER_MANT: begin
          if (a == int'(CODE_D) || a == int'(CODE_E)) scan_ph = PH_EXP_SIGN;
          else ends = 1'b1;
          done = 1'b1;
        end
        PH_EXP_SIGN: begin
          scan_ph = PH_EXP_LEAD;
          if (c == int'(CODE_PLUS) || c == int'(CODE_MINUS)) begin
            exp_neg = (c == int'(CODE_MINUS));
            done = 1'b1;
          end
        end
        PH_EXP_LEAD: begin
          if (c == 0) done = 1'b1;
          else scan_ph = PH_EXP_DIG;
        end
        PH_EXP_DIG: begin
          if (a <= int'(DIGIT_MAX)) begin
            if (exp_ndig < int'(EXP_ACC_DIGITS)) exp_acc = exp_acc * 10 + c;
            if (exp_ndig < int'(EXP_SAT_DIGITS)) exp_ndig++;
          end else begin
            ends = 1'b1;
          end
          done = 1'b1;
        end
        default: done = 1'b1;
      endcase
    end
    return ends;
  endfunction

  // Feeds one accepted character to the model and leaves any digit run that
  // it completes in fresh_run.
  function automatic void track_char(int c, bit st, bit bd);
    int         n;
    int         expo;
    int         runlen;
    class_e     cls;
    digit_out_t item;
    if (st) begin
      dig_cnt  = 0;
      exp_corr = 0;
      exp_acc  = 0;
      exp_ndig = 0;
      exp_neg  = 1'b0;
      scan_ph  = bd ? PH_FRAC_LEAD : PH_INT_LEAD;
    end
    if (scan_ph == PH_IDLE) return;
    if (!scan_ends_token(c)) return;

    n = dig_cnt;
    expo = 0;
    if (n == 0) begin
      cls = CLS_ZERO;
    end else if (exp_ndig >= exp_dig_lim) begin
      cls = exp_neg ? CLS_UNDERFLOW : CLS_OVERFLOW;
    end else begin
      expo = (exp_neg ? -exp_acc : exp_acc) + exp_corr;
      if (expo + n - 1 >= ovf_exp) cls = CLS_OVERFLOW;
      else if (expo + n <= unf_exp) cls = CLS_UNDERFLOW;
      else if (n <= exact_dig && ((expo < 0) ? -expo : expo) <= exact_pow) cls = CLS_EXACT;
      else if (expo > exact_pow && expo - exact_pow + n <= exact_dig) cls = CLS_SCALED;
      else cls = CLS_GENERAL;
    end
    if (cls < CLS_EXACT) expo = 0;
    if (expo > 511) expo = 511;
    if (expo < -512) expo = -512;

    runlen = (n == 0) ? 1 : n;
    for (int i = 0; i < runlen; i++) begin
      item.digit = 5'((n == 0) ? 0 : dig_mem[i]);
      item.count = 5'(n);
      item.last  = (i == runlen - 1);
      item.expo  = 10'(item.last ? expo : 0);
      item.cls   = cls;
      fresh_run.push_back(item);
    end
    scan_ph = PH_IDLE;
  endfunction

  function automatic void reset_model();
    ovf_exp     = int'(OVF_EXP_RST);
    unf_exp     = int'($signed(UNF_EXP_RST));
    exact_dig   = int'(EXACT_DIG_RST);
    exact_pow   = int'(EXACT_POW_RST);
    exp_dig_lim = int'(EXP_DIG_RST);
    scan_ph     = PH_IDLE;
    dig_cnt     = 0;
    exp_corr    = 0;
    exp_acc     = 0;
    exp_ndig    = 0;
    exp_neg     = 1'b0;
  endfunction

  function automatic char_row_t plain(int c, bit st, bit bd);
    char_row_t r;
    r = '0;
    r.code  = c[7:0];
    r.start = st;
    r.dot   = bd;
    return r;
  endfunction

  // Row whose single result is obvious: zero, overflow or underflow.
  function automatic char_row_t known(int c, bit st, bit bd, int d, int n, class_e cls);
    char_row_t r;
    r = plain(c, st, bd);
    r.known      = 1'b1;
    r.want.digit = 5'(d);
    r.want.count = 5'(n);
    r.want.expo  = '0;
    r.want.cls   = cls;
    r.want.last  = 1'b1;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, int v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v[12:0];
    @(negedge clk_i);
  endtask

  // Only called while the scanner is idle and no result is outstanding.
  task automatic set_limits(int ovf, int unf, int edl, int epl, int xdl);
    logic [12:0] u;
    write_reg(REG_OVF_EXP, ovf);
    write_reg(REG_UNF_EXP, unf);
    write_reg(REG_EXACT_DIG, edl);
    write_reg(REG_EXACT_POW, epl);
    write_reg(REG_EXP_DIG, xdl);
    cfg_we_i <= 1'b0;
    u = unf[12:0];
    ovf_exp     = ovf & 'hFFF;
    unf_exp     = int'($signed(u));
    exact_dig   = edl & 'h1F;
    exact_pow   = epl & 'h3F;
    exp_dig_lim = xdl & 'h7;
    settings++;
  endtask

  task automatic put_char(logic [7:0] code, bit st, bit bd, bit fixed = 1'b0,
                          digit_out_t want = '0);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= {bd, st};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    total_chars++;
    if (st || scan_ph != PH_IDLE) live_chars++;
    fresh_run.delete();
    track_char(int'($signed(code)), st, bd);
    if (fixed) begin
      pending_digits.push_back(want);
    end else begin
      foreach (fresh_run[i]) pending_digits.push_back(fresh_run[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic tok_char(int c);
    put_char(c[7:0], tok_first, tok_first ? tok_dot : ($urandom_range(7) == 0));
    tok_first = 1'b0;
  endtask

  function automatic int rand_digit();
    if ($urandom_range(15) == 0) return -int'($urandom_range(1, 9));
    return int'($urandom_range(9));
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(0, 3);
    if (r < 90) return $urandom_range(4, 12);
    return $urandom_range(13, 30);
  endfunction

  // Any code that cannot continue a number, of either sign.
  function automatic int end_code();
    int c;
    int a;
    do begin
      c = int'($urandom_range(255)) - 128;
      a = (c < 0) ? -c : c;
    end while (a <= 9 || a == int'(CODE_D) || a == int'(CODE_E) || a == int'(CODE_DOT));
    return c;
  endfunction

  task automatic random_token();
    int nexp;
    int k;
    int r;
    bit has_dot;
    tok_first = 1'b1;
    if ($urandom_range(99) < 15) begin
      // Arbitrary codes and flags: idle junk, stray dot flags, mid-token restarts.
      k = $urandom_range(1, 6);
      repeat (k) put_char(8'($urandom), $urandom_range(3) == 0, $urandom_range(1) == 1);
    end else begin
      tok_dot = ($urandom_range(5) == 0);
      if ($urandom_range(2) == 0) repeat ($urandom_range(1, 3)) tok_char(0);
      has_dot = 1'b1;
      if (!tok_dot) begin
        repeat (rand_len()) tok_char(rand_digit());
        has_dot = ($urandom_range(1) == 1);
        if (has_dot) tok_char(($urandom_range(7) == 0) ? -int'(CODE_DOT) : int'(CODE_DOT));
      end
      if (has_dot) begin
        if ($urandom_range(2) == 0) repeat ($urandom_range(1, 4)) tok_char(0);
        repeat (rand_len()) tok_char(rand_digit());
      end
      if ($urandom_range(9) < 6) begin
        k = $urandom_range(1) ? int'(CODE_D) : int'(CODE_E);
        tok_char(($urandom_range(7) == 0) ? -k : k);
        case ($urandom_range(2))
          0: tok_char(int'(CODE_PLUS));
          1: tok_char(int'(CODE_MINUS));
          default: ;
        endcase
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) tok_char(0);
        r = $urandom_range(99);
        nexp = (r < 15) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(4, 8);
        repeat (nexp) tok_char(rand_digit());
      end
      tok_char(end_code());
    end
  endtask

  // Closes any open token, then holds the sender until every run is out.
  task automatic settle();
    if (scan_ph != PH_IDLE) put_char(CODE_SPACE, 1'b0, 1'b0);
    s_axis_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_output
    digit_out_t got;
    digit_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.digit = m_axis_tdata[4:0];
      got.count = m_axis_tdata[9:5];
      got.expo  = m_axis_tdata[19:10];
      got.cls   = class_e'(m_axis_tuser);
      got.last  = m_axis_tlast;
      if (pending_digits.size() == 0) begin
        errors++;
        if (errors < 40)
          $display("%0t: unexpected item: digit %0d count %0d exp %0d class %0d last %0d",
                   $time, got.digit, got.count, got.expo, got.cls, got.last);
      end else begin
        want = pending_digits.pop_front();
        checked++;
        if (want.last) class_seen[int'(want.cls)]++;
        if (got.digit !== want.digit || got.count !== want.count ||
            got.expo !== want.expo || got.cls !== want.cls || got.last !== want.last) begin
          errors++;
          // Fields in order: digit, count, exponent, class, last.
          if (errors < 40)
            $display("%0t: mismatch, expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                     $time, want.digit, want.count, want.expo, want.cls, want.last,
                     got.digit, got.count, got.expo, got.cls, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb_decimal_number_token_scanner_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int phase_base;
    reset_model();
    foreach (class_seen[i]) class_seen[i] = 0;
    dir_rows = '{
      plain(127, 1'b0, 1'b0),                        // idle character, ignored
      plain(0, 1'b0, 1'b1),                          // dot flag alone, ignored
      known(-128, 1'b1, 1'b0, 0, 0, CLS_ZERO),       // bad first character
      plain(0, 1'b1, 1'b0),
      plain(0, 1'b0, 1'b0),
      known(CODE_SPACE, 1'b0, 1'b0, 0, 0, CLS_ZERO), // only leading zeros
      plain(1, 1'b1, 1'b0),
      plain(CODE_E, 1'b0, 1'b0),
      plain(4, 1'b0, 1'b0),
      plain(0, 1'b0, 1'b0),
      plain(0, 1'b0, 1'b0),
      known(CODE_SPACE, 1'b0, 1'b0, 1, 1, CLS_OVERFLOW),
      plain(5, 1'b1, 1'b0),
      plain(CODE_D, 1'b0, 1'b0),
      plain(CODE_MINUS, 1'b0, 1'b0),
      plain(4, 1'b0, 1'b0),
      plain(0, 1'b0, 1'b0),
      plain(0, 1'b0, 1'b0),
      known(CODE_SPACE, 1'b0, 1'b0, 5, 1, CLS_UNDERFLOW),
      plain(-3, 1'b1, 1'b0),                         // negative digit code
      plain(CODE_DOT, 1'b0, 1'b0),
      plain(7, 1'b1, 1'b1),                          // restart after a consumed dot
      plain(2, 1'b0, 1'b0),
      plain(CODE_D, 1'b0, 1'b0),
      plain(CODE_PLUS, 1'b0, 1'b0),
      plain(CODE_SPACE, 1'b0, 1'b0)                  // exponent with no digits
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      put_char(dir_rows[i].code, dir_rows[i].start, dir_rows[i].dot,
               dir_rows[i].known, dir_rows[i].want);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 74; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 74; end
        default: begin send_gap_pct = 33; stall_pct = 33; end
      endcase
      case (p)
        0: set_limits(1, -1, 1, 0, 1);
        1: set_limits(4095, -4095, 25, 63, 7);
        2: set_limits(12, -12, 6, 4, 2);
        3: set_limits($urandom_range(1, 4095), -int'($urandom_range(1, 4095)),
                      $urandom_range(1, 25), $urandom_range(0, 63), $urandom_range(1, 7));
        4: set_limits(int'(OVF_EXP_RST), int'($signed(UNF_EXP_RST)), int'(EXACT_DIG_RST),
                      int'(EXACT_POW_RST), int'(EXP_DIG_RST));
        default: set_limits(30, -30, 10, 8, 3);
      endcase
      phase_base = live_chars;
      while (live_chars - phase_base < PHASE_CHARS) random_token();
      settle();
    end

    repeat (12) @(posedge clk_i);
    $display("Sent %0d characters (%0d inside tokens), checked %0d digit items, %0d settings.",
             total_chars, live_chars, checked, settings);
    $display("Runs by class: zero %0d, overflow %0d, underflow %0d, exact %0d, scaled %0d, %s %0d.",
             class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4],
             "general", class_seen[5]);
    if (errors == 0) begin
      $display("tb_decimal_number_token_scanner_top: PASS");
    end else begin
      $display("tb_decimal_number_token_scanner_top: FAIL");
    end
    $finish;
  end

endmodule
